### hdl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_DELAY(label, ante, n, cons)
`endif
`endif

### hdl/rgbhsv_pkg.sv
`default_nettype none
package rgbhsv_pkg;
  localparam int COMP_BITS = 8;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = FRAC_BITS + 1;
  localparam int SUM_BITS = COMP_BITS + 1;
  localparam int NUM_BITS = COMP_BITS + 3;
  localparam logic [COMP_BITS-1:0] COMP_MAX = {COMP_BITS{1'b1}};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [15:0] hue;
    logic [16:0] sat_hsv;
    logic [16:0] sat_hsl;
    logic [7:0]  value;
    logic [8:0]  lightness_x2;
  } hsx_t;

  typedef struct packed {
    logic [COMP_BITS-1:0] value;
    logic [SUM_BITS-1:0]  sum;
    logic                 hue_zero;
    logic                 hsv_zero;
    logic                 hsl_zero;
  } side_t;
endpackage
`default_nettype wire

### hdl/rgb_to_hsv_hsl_core.sv
// Channel   Ports                     Direction
// request   start, in_data / busy     in / out
// result    out_valid, out_data       out
//
// One request is taken every cycle; busy stays low.
// Each result reaches the ports through two front stages, seventeen divider stages
// (the three restoring dividers run side by side, one quotient bit per stage) and
// the output register.
// Reset clears the valid bits of the pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
`include "assert_macros.svh"
module rgb_to_hsv_hsl_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire rgbhsv_pkg::pixel_t in_data,
  output logic                    out_valid,
  output rgbhsv_pkg::hsx_t        out_data
);
  localparam int CB = rgbhsv_pkg::COMP_BITS;
  localparam int SB = rgbhsv_pkg::SUM_BITS;
  localparam int NB = rgbhsv_pkg::NUM_BITS;
  localparam int QW = rgbhsv_pkg::QUOT_BITS;
  localparam logic [QW-1:0] SAT_ONE = QW'(1) << rgbhsv_pkg::FRAC_BITS;

  logic          accept;
  logic [CB-1:0] r_in, g_in, b_in, mx_nxt, mn_nxt;
  logic [CB-1:0] r_r, g_r, b_r, mx_r, mn_r;
  logic          v1_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign r_in   = in_data.red[CB-1:0];
  assign g_in   = in_data.green[CB-1:0];
  assign b_in   = in_data.blue[CB-1:0];

  always_comb begin
    mx_nxt = r_in;
    if (g_in > mx_nxt) mx_nxt = g_in;
    if (b_in > mx_nxt) mx_nxt = b_in;
    mn_nxt = r_in;
    if (g_in < mn_nxt) mn_nxt = g_in;
    if (b_in < mn_nxt) mn_nxt = b_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    r_r  <= r_in;
    g_r  <= g_in;
    b_r  <= b_in;
    mx_r <= mx_nxt;
    mn_r <= mn_nxt;
  end

  logic [CB-1:0] c;
  logic [SB-1:0] sum;
  logic [NB-1:0] c_ext, r_ext, g_ext, b_ext, six_c, num_nxt;
  logic [SB-1:0] dl_nxt;
  logic [SB:0]   two_m_minus;
  rgbhsv_pkg::side_t side_nxt;

  logic [NB-1:0] num_r, six_c_r;
  logic [CB-1:0] c_r, mx2_r;
  logic [SB-1:0] dl_r;
  rgbhsv_pkg::side_t side2_r;
  logic          v2_r;

  always_comb begin
    c           = mx_r - mn_r;
    sum         = {1'b0, mx_r} + {1'b0, mn_r};
    c_ext       = NB'(c);
    r_ext       = NB'(r_r);
    g_ext       = NB'(g_r);
    b_ext       = NB'(b_r);
    six_c       = (c_ext << 2) + (c_ext << 1);
    if (g_r == mx_r) begin
      num_nxt = b_ext + (c_ext << 1) - r_ext;
    end else if (b_r == mx_r) begin
      num_nxt = r_ext + (c_ext << 2) - g_ext;
    end else if (g_r >= b_r) begin
      num_nxt = g_ext - b_ext;
    end else begin
      num_nxt = six_c + g_ext - b_ext;
    end
    two_m_minus = {rgbhsv_pkg::COMP_MAX, 1'b0} - {1'b0, sum};
    dl_nxt      = (sum <= SB'(rgbhsv_pkg::COMP_MAX)) ? sum : two_m_minus[SB-1:0];
    side_nxt.value    = mx_r;
    side_nxt.sum      = sum;
    side_nxt.hue_zero = (c == '0);
    side_nxt.hsv_zero = (mx_r == '0);
    side_nxt.hsl_zero = (mx_r == '0) || (mn_r == rgbhsv_pkg::COMP_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    num_r   <= num_nxt;
    six_c_r <= six_c;
    c_r     <= c;
    mx2_r   <= mx_r;
    dl_r    <= dl_nxt;
    side2_r <= side_nxt;
  end

  logic [QW-1:0] q_hue, q_hsv, q_hsl;

  rgbhsv_div #(.XW(NB), .DW(NB)) u_div_hue (
    .clk(clk), .x(num_r), .d(six_c_r), .q(q_hue)
  );
  rgbhsv_div #(.XW(CB), .DW(CB)) u_div_hsv (
    .clk(clk), .x(c_r), .d(mx2_r), .q(q_hsv)
  );
  rgbhsv_div #(.XW(CB), .DW(SB)) u_div_hsl (
    .clk(clk), .x(c_r), .d(dl_r), .q(q_hsl)
  );

  rgbhsv_pkg::side_t side_r [QW];
  logic [QW-1:0]     vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
    end else begin
      vd_r <= {vd_r[QW-2:0], v2_r};
    end
    side_r[0] <= side2_r;
    for (int i = 1; i < QW; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  rgbhsv_pkg::hsx_t out_nxt, out_data_r;
  logic             out_valid_r;

  always_comb begin
    out_nxt.hue          = side_r[QW-1].hue_zero ? '0 : q_hue[15:0];
    out_nxt.sat_hsv      = side_r[QW-1].hsv_zero ? '0 : q_hsv;
    out_nxt.sat_hsl      = side_r[QW-1].hsl_zero ? '0 : q_hsl;
    out_nxt.value        = 8'(side_r[QW-1].value);
    out_nxt.lightness_x2 = 9'(side_r[QW-1].sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vd_r[QW-1];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_DELAY(a_req_to_result, accept, 20, out_valid)
  `ASSERT_DELAY(a_no_spurious, !accept, 20, !out_valid)
  `ASSERT_IMPLY(a_sat_range, out_valid, (out_data.sat_hsv <= SAT_ONE) && (out_data.sat_hsl <= SAT_ONE))
endmodule
`default_nettype wire

### hdl/rgbhsv_div.sv
`default_nettype none
module rgbhsv_div #(
  parameter int XW = 8,
  parameter int DW = 8
) (
  input  wire logic                             clk,
  input  wire logic [XW-1:0]                    x,
  input  wire logic [DW-1:0]                    d,
  output logic      [rgbhsv_pkg::QUOT_BITS-1:0] q
);
  localparam int QW = rgbhsv_pkg::QUOT_BITS;

  logic [DW-1:0] rem_r [QW];
  logic [DW-1:0] d_r   [QW];
  logic [QW-1:0] q_r   [QW];
  logic [XW+DW-1:0] x_ext;

  assign x_ext = {{DW{1'b0}}, x} >> 1;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          bit_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (i == 0) begin : g_first
      assign rem_in = x_ext[DW-1:0];
      assign d_in   = d;
      assign q_in   = '0;
      assign bit_in = x[0];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign d_in   = d_r[i-1];
      assign q_in   = q_r[i-1];
      assign bit_in = 1'b0;
    end

    always_comb begin
      trial   = {rem_in, bit_in};
      ge      = trial >= {1'b0, d_in};
      diff    = trial - {1'b0, d_in};
      rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
      q_nxt   = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      d_r[i]   <= d_in;
      q_r[i]   <= q_nxt;
    end
  end

  assign q = q_r[QW-1];
endmodule
`default_nettype wire

### tb/sv/rgb_to_hsv_hsl_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module rgb_to_hsv_hsl_core_tb;

  class hsx_scoreboard;
    rgbhsv_pkg::hsx_t expected_q[$];
    int errors;
    int results;

    function rgbhsv_pkg::hsx_t convert(rgbhsv_pkg::pixel_t px);
      rgbhsv_pkg::hsx_t h;
      logic [31:0] r, g, b, mx, mn, c, sum, num, six_c;
      r = 32'(px.red);
      g = 32'(px.green);
      b = 32'(px.blue);
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      sum = mx + mn;
      six_c = 6 * c;
      if (c == 0) begin
        h.hue = '0;
      end else begin
        if (g == mx) num = b + 2 * c - r;
        else if (b == mx) num = r + 4 * c - g;
        else if (g >= b) num = g - b;
        else num = six_c + g - b;
        h.hue = 16'((num << rgbhsv_pkg::FRAC_BITS) / six_c);
      end
      h.sat_hsv = (mx == 0) ? '0 : 17'((c << rgbhsv_pkg::FRAC_BITS) / mx);
      if (mx == 0 || mn == 255) h.sat_hsl = '0;
      else if (sum <= 255) h.sat_hsl = 17'((c << rgbhsv_pkg::FRAC_BITS) / sum);
      else h.sat_hsl = 17'((c << rgbhsv_pkg::FRAC_BITS) / (510 - sum));
      h.value = mx[7:0];
      h.lightness_x2 = sum[8:0];
      return h;
    endfunction

    function void note_request(rgbhsv_pkg::pixel_t px);
      expected_q.push_back(convert(px));
    endfunction

    function void check_result(rgbhsv_pkg::hsx_t got);
      rgbhsv_pkg::hsx_t exp_r;
      results++;
      if (expected_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.hue !== exp_r.hue) begin
        $error("hue exp %0d got %0d", exp_r.hue, got.hue); errors++;
      end
      if (got.sat_hsv !== exp_r.sat_hsv) begin
        $error("sat_hsv exp %0d got %0d", exp_r.sat_hsv, got.sat_hsv); errors++;
      end
      if (got.sat_hsl !== exp_r.sat_hsl) begin
        $error("sat_hsl exp %0d got %0d", exp_r.sat_hsl, got.sat_hsl); errors++;
      end
      if (got.value !== exp_r.value) begin
        $error("value exp %0d got %0d", exp_r.value, got.value); errors++;
      end
      if (got.lightness_x2 !== exp_r.lightness_x2) begin
        $error("lightness_x2 exp %0d got %0d", exp_r.lightness_x2, got.lightness_x2);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  rgbhsv_pkg::pixel_t in_data = '0;
  logic out_valid;
  rgbhsv_pkg::hsx_t out_data;
  hsx_scoreboard sb = new();
  int idle_cycles = 0;
  int sent = 0;
  int idle_pct = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  rgb_to_hsv_hsl_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input rgbhsv_pkg::pixel_t px);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_data <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(px);
    sent++;
  endtask

  task automatic send_rgb(input logic [7:0] r, g, b);
    rgbhsv_pkg::pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    send_pixel(px);
  endtask

  task automatic send_random(input int n);
    rgbhsv_pkg::pixel_t px;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: begin
          px.red = 8'($urandom);
          px.green = px.red;
          px.blue = px.red;
        end
        1: begin
          px.red = 8'($urandom);
          px.green = 8'($urandom);
          px.blue = ($urandom_range(1)) ? px.red : px.green;
        end
        2: begin
          px.red = $urandom_range(1) ? 8'hff : 8'h00;
          px.green = 8'($urandom);
          px.blue = $urandom_range(1) ? 8'hff : 8'h00;
        end
        default: px = 24'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Grey, black, white, primaries, secondaries and both hue wrap sides.
    send_rgb(0, 0, 0);
    send_rgb(255, 255, 255);
    send_rgb(128, 128, 128);
    send_rgb(255, 0, 0);
    send_rgb(0, 255, 0);
    send_rgb(0, 0, 255);
    send_rgb(255, 255, 0);
    send_rgb(0, 255, 255);
    send_rgb(255, 0, 255);
    send_rgb(255, 0, 1);
    send_rgb(255, 1, 0);
    send_rgb(127, 0, 0);
    send_rgb(128, 0, 0);
    send_rgb(255, 255, 254);
    send_rgb(255, 128, 0);
    send_rgb(1, 0, 0);
    send_rgb(255, 254, 254);
    send_rgb(200, 100, 100);
    send_rgb(100, 200, 200);
    send_rgb(170, 85, 0);
    drain();
    idle_pct = 27;
    send_random(130);
    drain();
    idle_pct = 48;
    send_random(130);
    idle_pct = 0;
    send_random(140);
    drain();
    $display("Sent %0d pixels (grey, black, white, primaries, random), checked %0d results.",
             sent, sb.results);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
